// ===== design/dmps_pkg.sv =====
`timescale 1ns / 1ps

package dmps_pkg;

  // Widest row the row store can hold.
  localparam int MAX_ROWS = 128;

  localparam int ADDR_W = $clog2(MAX_ROWS);
  localparam int ROW_W  = $clog2(2 * MAX_ROWS - 1);
  localparam int N_W    = $clog2(MAX_ROWS + 1);

  localparam int CFG_W  = 8;
  localparam int CELL_W = 15;
  localparam int SUM_W  = 23;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_FIRST  = 2'd0;
  localparam mode_t MODE_WIDEN  = 2'd1;
  localparam mode_t MODE_NARROW = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] col;
    mode_t             mode;
    logic              use_above;
    logic              use_left;
    logic              row_end;
    logic              diamond_end;
  } cell_ctrl_t;

  typedef struct packed {
    logic s2_valid;
    logic s2_fire;
    logic s2_end;
  } dp_status_t;

endpackage

// ===== design/dmps_row_ram.sv =====
`timescale 1ns / 1ps

module dmps_row_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [dmps_pkg::ADDR_W-1:0] waddr,
  input  logic [dmps_pkg::SUM_W-1:0]  wdata,
  input  logic                       re,
  input  logic [dmps_pkg::ADDR_W-1:0] raddr_a,
  input  logic [dmps_pkg::ADDR_W-1:0] raddr_b,
  output logic [dmps_pkg::SUM_W-1:0]  rdata_a,
  output logic [dmps_pkg::SUM_W-1:0]  rdata_b
);
  import dmps_pkg::*;

  logic [SUM_W-1:0] mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data returns the old contents on a same-cycle write; the datapath forwards.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/dmps_seq.sv =====
`timescale 1ns / 1ps

module dmps_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        row_count_we,
  input  logic [dmps_pkg::CFG_W-1:0]  row_count,
  input  logic                        accept,
  output dmps_pkg::cell_ctrl_t        ctrl,
  output logic [dmps_pkg::ADDR_W-1:0] raddr_right
);
  import dmps_pkg::*;

  logic [CFG_W-1:0]  rows_cfg;
  logic [ROW_W-1:0]  row_index;
  logic [ADDR_W-1:0] col_index;

  logic [N_W-1:0]    n_eff;
  logic [ROW_W:0]    n_x;
  logic [ROW_W:0]    r_x;
  logic [ROW_W:0]    c_x;
  logic [ROW_W:0]    width;
  logic              widen;

  always_comb begin
    if (rows_cfg == '0) begin
      n_eff = N_W'(1);
    end else if (32'(rows_cfg) > MAX_ROWS) begin
      n_eff = N_W'(MAX_ROWS);
    end else begin
      n_eff = N_W'(rows_cfg);
    end

    n_x   = (ROW_W + 1)'(n_eff);
    r_x   = {1'b0, row_index};
    c_x   = (ROW_W + 1)'(col_index);
    widen = (r_x < n_x);
    width = widen ? (r_x + 1'b1) : ((n_x << 1) - 1'b1 - r_x);

    ctrl.col         = col_index;
    ctrl.use_above   = (c_x < r_x);
    ctrl.use_left    = (col_index != '0);
    ctrl.row_end     = ((c_x + 1'b1) == width);
    ctrl.diamond_end = ctrl.row_end && ((r_x + 1'b1) >= ((n_x << 1) - 1'b1));

    if (row_index == '0) begin
      ctrl.mode = MODE_FIRST;
    end else if (widen) begin
      ctrl.mode = MODE_WIDEN;
    end else begin
      ctrl.mode = MODE_NARROW;
    end

    // Only meaningful in the narrowing half, where it always stays inside the store.
    raddr_right = col_index + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg  <= CFG_W'(1);
      row_index <= '0;
      col_index <= '0;
    end else if (row_count_we) begin
      rows_cfg  <= row_count;
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      if (ctrl.row_end) begin
        col_index <= '0;
        row_index <= ctrl.diamond_end ? '0 : row_index + 1'b1;
      end else begin
        col_index <= col_index + 1'b1;
      end
    end
  end

endmodule

// ===== design/dmps_datapath.sv =====
`timescale 1ns / 1ps

module dmps_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [dmps_pkg::CELL_W-1:0] cell_value,
  input  dmps_pkg::cell_ctrl_t        ctrl,
  input  logic [dmps_pkg::ADDR_W-1:0] raddr_right,
  input  logic                        cfg_clear,
  input  logic                        sum_ready,
  output logic                        cell_ready,
  output logic                        sum_valid,
  output logic [dmps_pkg::SUM_W-1:0]  max_sum,
  output dmps_pkg::dp_status_t        status
);
  import dmps_pkg::*;

  logic              s2_valid;
  cell_ctrl_t        s2_ctrl;
  logic [CELL_W-1:0] s2_value;
  logic              fwd_above;
  logic              fwd_right;
  logic [SUM_W-1:0]  fwd_data;
  logic [SUM_W-1:0]  prior_left_sum;

  logic [SUM_W-1:0]  rdata_above;
  logic [SUM_W-1:0]  rdata_right;
  logic [SUM_W-1:0]  above_raw;
  logic [SUM_W-1:0]  right_raw;
  logic [SUM_W-1:0]  above_pick;
  logic [SUM_W-1:0]  other_pick;
  logic [SUM_W-1:0]  best;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum;
  logic              s2_fire;

  dmps_row_ram u_ram (
    .clk     (clk),
    .we      (s2_fire),
    .waddr   (s2_ctrl.col),
    .wdata   (sum),
    .re      (accept),
    .raddr_a (ctrl.col),
    .raddr_b (raddr_right),
    .rdata_a (rdata_above),
    .rdata_b (rdata_right)
  );

  always_comb begin
    // A finished diamond may wait only while the output register still holds the last one.
    s2_fire    = s2_valid && (!s2_ctrl.diamond_end || !sum_valid || sum_ready);
    cell_ready = !s2_valid || s2_fire;

    above_raw = fwd_above ? fwd_data : rdata_above;
    right_raw = fwd_right ? fwd_data : rdata_right;

    case (s2_ctrl.mode)
      MODE_WIDEN: begin
        above_pick = s2_ctrl.use_above ? above_raw : '0;
        other_pick = s2_ctrl.use_left ? prior_left_sum : '0;
      end
      MODE_NARROW: begin
        above_pick = above_raw;
        other_pick = right_raw;
      end
      default: begin
        above_pick = '0;
        other_pick = '0;
      end
    endcase

    best     = (above_pick > other_pick) ? above_pick : other_pick;
    sum_wide = (SUM_W + 1)'(s2_value) + (SUM_W + 1)'(best);
    sum      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    status.s2_valid = s2_valid;
    status.s2_fire  = s2_fire;
    status.s2_end   = s2_ctrl.diamond_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      sum_valid      <= 1'b0;
      prior_left_sum <= '0;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end

      if (sum_valid && sum_ready) begin
        sum_valid <= 1'b0;
      end
      if (s2_fire && s2_ctrl.diamond_end) begin
        sum_valid <= 1'b1;
      end

      if (cfg_clear) begin
        prior_left_sum <= '0;
      end else if (s2_fire) begin
        if (s2_ctrl.row_end) begin
          prior_left_sum <= '0;
        end else if (s2_ctrl.mode == MODE_WIDEN) begin
          prior_left_sum <= above_pick;
        end
      end
    end
  end

  // The only write that can race a new read is the one retiring in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_ctrl   <= ctrl;
      s2_value  <= cell_value;
      fwd_above <= s2_fire && (s2_ctrl.col == ctrl.col);
      fwd_right <= s2_fire && (s2_ctrl.col == raddr_right);
      fwd_data  <= sum;
    end
    if (s2_fire && s2_ctrl.diamond_end) begin
      max_sum <= sum;
    end
  end

endmodule

// ===== design/diamond_max_path_sum.sv =====
`timescale 1ns / 1ps

// Maximum path sum through a diamond of 2n-1 rows, one cell request per clock. Cells enter
// in row order on cell_valid/cell_ready and each passes a second stage: the row store is
// read in the accept cycle and the updated sum is written back when the cell leaves that
// stage, with a bypass of that write into the read that follows it, so one cell is accepted
// every cycle. The best sum is loaded into the output register max_sum as the last cell
// leaves that stage and is held; the cell channel stalls only when a diamond ends while the
// sum of the previous diamond has not yet been taken. Writing row_count starts a new diamond.
module diamond_max_path_sum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        row_count_we,
  input  logic [dmps_pkg::CFG_W-1:0]  row_count,
  input  logic                        cell_valid,
  output logic                        cell_ready,
  input  logic [dmps_pkg::CELL_W-1:0] cell_value,
  output logic                        sum_valid,
  input  logic                        sum_ready,
  output logic [dmps_pkg::SUM_W-1:0]  max_sum
);
  import dmps_pkg::*;

  logic              accept;
  cell_ctrl_t        ctrl;
  logic [ADDR_W-1:0] raddr_right;
  dp_status_t        status;

  assign accept = cell_valid && cell_ready;

  dmps_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .row_count_we (row_count_we),
    .row_count    (row_count),
    .accept       (accept),
    .ctrl         (ctrl),
    .raddr_right  (raddr_right)
  );

  dmps_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cell_value  (cell_value),
    .ctrl        (ctrl),
    .raddr_right (raddr_right),
    .cfg_clear   (row_count_we),
    .sum_ready   (sum_ready),
    .cell_ready  (cell_ready),
    .sum_valid   (sum_valid),
    .max_sum     (max_sum),
    .status      (status)
  );

  // A cell may hold in the second stage only when it closes a diamond and the output is full.
  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (status.s2_valid && !status.s2_fire) |-> (status.s2_end && sum_valid && !sum_ready))
    else $error("second stage stalled without a pending result");

  // A retiring final cell always loads the output register.
  a_end_loads_output: assert property (@(posedge clk) disable iff (rst)
    (status.s2_fire && status.s2_end) |=> sum_valid)
    else $error("diamond end did not produce a result");

  // A row_count write restarts the diamond at its first cell.
  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    row_count_we |=> (ctrl.mode == MODE_FIRST && ctrl.col == '0))
    else $error("configuration write did not restart the diamond");

endmodule

// ===== tb/tb_diamond_max_path_sum.sv =====
`timescale 1ns / 1ps

module tb_diamond_max_path_sum;
  import dmps_pkg::*;

  // Cycles the block may still spend on a cell after its last result has left.
  localparam int SETTLE_CYCLES = 4;

  logic              clk;
  logic              rst;
  logic              row_count_we;
  logic [CFG_W-1:0]  row_count;
  logic              cell_valid;
  logic              cell_ready;
  logic [CELL_W-1:0] cell_value;
  logic              sum_valid;
  logic              sum_ready;
  logic [SUM_W-1:0]  max_sum;

  diamond_max_path_sum u_top (
    .clk          (clk),
    .rst          (rst),
    .row_count_we (row_count_we),
    .row_count    (row_count),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_value   (cell_value),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .max_sum      (max_sum)
  );

  // Predicted state of the diamond walk.
  logic [SUM_W-1:0] best_row [MAX_ROWS];
  logic [CFG_W-1:0] rows_cfg;
  int unsigned      cur_row;
  int unsigned      cur_col;
  logic [SUM_W-1:0] left_keep;

  logic [SUM_W-1:0] sum_expect_q[$];
  logic [SUM_W-1:0] sum_want;

  int err_count;
  int cells_sent;
  int sums_seen;
  int send_idle_pct;
  int sum_stall_pct;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic int unsigned rows_eff();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > MAX_ROWS) return MAX_ROWS;
    return 32'(rows_cfg);
  endfunction

  function automatic void predict_cell(input logic [CELL_W-1:0] v);
    int unsigned      n;
    int unsigned      w;
    int unsigned      k;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] other;
    logic [SUM_W-1:0] best;
    logic [SUM_W:0]   total;
    n = rows_eff();
    w = (cur_row < n) ? cur_row + 1 : 2 * n - 1 - cur_row;
    k = (cur_col >= MAX_ROWS) ? MAX_ROWS - 1 : cur_col;
    best = '0;
    if (cur_row == 0) begin
      best = '0;
    end else if (cur_row < n) begin
      // Widening half: the cell above-left was overwritten one step ago, so it is kept aside.
      above = (k < cur_row) ? best_row[ADDR_W'(k)] : '0;
      other = (k >= 1) ? left_keep : '0;
      best = (above > other) ? above : other;
      left_keep = above;
    end else begin
      above = best_row[ADDR_W'(k)];
      other = (k + 1 < MAX_ROWS) ? best_row[ADDR_W'(k + 1)] : '0;
      best = (above > other) ? above : other;
    end
    total = {1'b0, best} + (SUM_W + 1)'(v);
    if (total > SUM_MAX) total = {1'b0, SUM_MAX};
    best_row[ADDR_W'(k)] = total[SUM_W-1:0];
    if (k + 1 < w) begin
      cur_col = k + 1;
    end else begin
      cur_col = 0;
      left_keep = '0;
      if (cur_row + 1 >= 2 * n - 1) begin
        cur_row = 0;
        sum_expect_q = {sum_expect_q, total[SUM_W-1:0]};
      end else begin
        cur_row = cur_row + 1;
      end
    end
  endfunction

  function automatic logic [CELL_W-1:0] pick_cell();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return CELL_W'($urandom_range(32767));
    if (sel < 60) return '0;
    if (sel < 70) return '1;
    return CELL_W'($urandom_range(15));
  endfunction

  task automatic send_cell(input logic [CELL_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_value <= v;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    cells_sent++;
    predict_cell(v);
  endtask

  task automatic wait_drained();
    cell_valid <= 1'b0;
    while (sum_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A write restarts the diamond, so it is only issued once the block has gone quiet.
  task automatic set_row_count(input logic [CFG_W-1:0] n);
    wait_drained();
    row_count_we <= 1'b1;
    row_count <= n;
    @(posedge clk);
    row_count_we <= 1'b0;
    rows_cfg = n;
    cur_row = 0;
    cur_col = 0;
    left_keep = '0;
  endtask

  task automatic test_reset_default();
    send_cell('0);
    send_cell('1);
  endtask

  task automatic test_zero_rows();
    set_row_count(8'd0);
    send_cell(15'h5555);
    send_cell(15'h2AAA);
  endtask

  task automatic test_three_rows();
    logic [CELL_W-1:0] vals [9];
    vals = '{15'd5, 15'd1, 15'd9, 15'd2, 15'd0, 15'd7, 15'd0, 15'd32767, 15'd3};
    set_row_count(8'd3);
    foreach (vals[i]) send_cell(vals[i]);
  endtask

  task automatic test_rewrite_midway();
    set_row_count(8'd128);
    repeat (5) send_cell(CELL_W'($urandom_range(32767)));
    set_row_count(8'd2);
    send_cell(15'd1);
    send_cell(15'd2);
    send_cell(15'd3);
    send_cell(15'd4);
  endtask

  // An oversized count clamps to the widest row, so part of such a diamond gives no result.
  // A complete diamond of full-scale cells follows.
  task automatic test_oversize_count();
    set_row_count(8'd255);
    repeat (100) send_cell('1);
    set_row_count(8'd10);
    repeat (100) send_cell('1);
  endtask

  task automatic test_random_diamonds(input int idle_pct, input int stall_pct,
                                      input int cell_goal, input int sum_goal);
    int          cells_start;
    int          sums_start;
    int unsigned sel;
    int unsigned n;
    logic [CFG_W-1:0] cfg;
    send_idle_pct = idle_pct;
    sum_stall_pct = stall_pct;
    cells_start = cells_sent;
    sums_start = sums_seen;
    while (cells_sent - cells_start < cell_goal || sums_seen - sums_start < sum_goal) begin
      sel = $urandom_range(99);
      if (sel < 8) cfg = 8'd0;
      else if (sel < 85) cfg = CFG_W'($urandom_range(8, 1));
      else cfg = CFG_W'($urandom_range(16, 9));
      set_row_count(cfg);
      n = rows_eff();
      repeat ($urandom_range(4, 1)) begin
        repeat (n * n) send_cell(pick_cell());
      end
      // Now and then leave a diamond unfinished; the next write abandons it.
      if (n > 1 && $urandom_range(9) == 0) begin
        repeat ($urandom_range(n * n - 1, 1)) send_cell(pick_cell());
      end
    end
  endtask

  initial begin
    sum_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && sum_valid && sum_ready) begin
        if (sum_expect_q.size() == 0) begin
          report_mismatch($sformatf("max_sum %0d with no diamond pending", max_sum));
        end else begin
          sum_want = sum_expect_q.pop_front();
          sums_seen++;
          if (max_sum !== sum_want)
            report_mismatch($sformatf("max_sum %0d, want %0d", max_sum, sum_want));
        end
      end
      sum_ready <= ($urandom_range(99) >= sum_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    row_count_we <= 1'b0;
    row_count <= '0;
    cell_valid <= 1'b0;
    cell_value <= '0;
    foreach (best_row[i]) best_row[i] = '0;
    rows_cfg = 8'd1;
    cur_row = 0;
    cur_col = 0;
    left_keep = '0;
    err_count = 0;
    cells_sent = 0;
    sums_seen = 0;
    send_idle_pct = 0;
    sum_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_zero_rows();
    test_three_rows();
    test_rewrite_midway();
    test_oversize_count();
    test_random_diamonds(0, 0, 200, 4);
    test_random_diamonds(62, 0, 200, 4);
    test_random_diamonds(0, 62, 200, 4);
    test_random_diamonds(6, 6, 200, 4);

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
